// ===== rtl/core/mcfq_pkg.sv =====
// shared types, codes and the plate format check for the multi-class fifo
// no dependencies
package mcfq_pkg;

   localparam int NUM_QUEUES  = 4;
   localparam int PLATE_BYTES = 8;
   localparam int PLATE_W     = 64;
   localparam int POWER_W     = 10;
   localparam int MODE_W      = 2;
   localparam int QSEL_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int OCC_W       = 5;
   localparam int CSR_IDX_W   = 1;

   localparam logic [MODE_W-1:0] MODE_ENQ   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POWER_FLOOR   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POWER_CEILING = 1'd1;

   localparam logic [POWER_W-1:0] POWER_FLOOR_RESET   = 10'd1;
   localparam logic [POWER_W-1:0] POWER_CEILING_RESET = 10'd1000;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_PLATE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POWER = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_BAD_MODE  = 3'd5;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                wr_en;
      logic                empty;
      logic                fwd_head;
   } op_info_type;

   function automatic logic plate_ok(input logic [PLATE_W-1:0] plate);
      logic [7:0] c;
      logic       ok;
      ok = 1'b1;
      for (int k = 0; k < PLATE_BYTES; k++) begin
         c = plate[PLATE_W-1-8*k -: 8];
         if (k >= 2 && k <= 5) begin
            ok = ok & (c >= 8'h30) & (c <= 8'h39);
         end else begin
            ok = ok & (c >= 8'h41) & (c <= 8'h5A);
         end
      end
      return ok;
   endfunction

endpackage

// ===== rtl/core/mcfq_store.sv =====
// shared plate store: one write port, two registered read ports
// depends on mcfq_pkg
module mcfq_store #(
   parameter int QUEUE_DEPTH = 16,
   localparam int AW = $clog2(4 * QUEUE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [mcfq_pkg::PLATE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr_a,
   input  logic [AW-1:0]               rd_addr_b,
   output logic [mcfq_pkg::PLATE_W-1:0] rd_data_a,
   output logic [mcfq_pkg::PLATE_W-1:0] rd_data_b
);
   import mcfq_pkg::*;

   localparam int DEPTH = 4 * QUEUE_DEPTH;

   logic [PLATE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/core/mcfq_qstate.sv =====
// per-queue head and count registers, operation checks and store addressing
// depends on mcfq_pkg
module mcfq_qstate #(
   parameter int QUEUE_DEPTH = 16,
   localparam int AW = $clog2(4 * QUEUE_DEPTH),
   localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [mcfq_pkg::MODE_W-1:0]   mode,
   input  logic [mcfq_pkg::QSEL_W-1:0]   queue_select,
   input  logic [mcfq_pkg::PLATE_W-1:0]  plate,
   input  logic [mcfq_pkg::POWER_W-1:0]  power,
   input  logic [mcfq_pkg::POWER_W-1:0]  power_floor,
   input  logic [mcfq_pkg::POWER_W-1:0]  power_ceiling,
   output mcfq_pkg::op_info_type         info,
   output logic [CW-1:0]                 count_new,
   output logic [AW-1:0]                 wr_addr,
   output logic [AW-1:0]                 head_addr,
   output logic [AW-1:0]                 tail_addr
);
   import mcfq_pkg::*;

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SW = ((HW > CW) ? HW : CW) + 1;

   logic [HW-1:0] head_ff [NUM_QUEUES];
   logic [CW-1:0] count_ff [NUM_QUEUES];

   logic [HW-1:0] h, h_new;
   logic [CW-1:0] n, n_new;
   logic [SW-1:0] wsum, woff, tsum, toff;
   logic [AW-1:0] base;

   always_comb begin
      n     = count_ff[queue_select];
      h     = head_ff[queue_select];
      h_new = h;
      n_new = n;
      info  = '0;
      unique case (mode)
         MODE_ENQ: begin
            if (!plate_ok(plate)) begin
               info.status = STATUS_BAD_PLATE;
            end else if (!(power > power_floor && power < power_ceiling)) begin
               info.status = STATUS_BAD_POWER;
            end else if (n >= CW'(QUEUE_DEPTH)) begin
               info.status = STATUS_FULL;
            end else begin
               info.status = STATUS_OK;
               info.wr_en  = 1'b1;
               n_new       = n + CW'(1);
            end
         end
         MODE_DEQ: begin
            if (n == '0) begin
               info.status = STATUS_EMPTY;
            end else begin
               info.status = STATUS_OK;
               h_new = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + HW'(1);
               n_new = n - CW'(1);
            end
         end
         MODE_QUERY: begin
            info.status = (n == '0) ? STATUS_EMPTY : STATUS_OK;
         end
         default: begin
            info.status = STATUS_BAD_MODE;
         end
      endcase
      info.empty    = (n_new == '0);
      info.fwd_head = info.wr_en && (n == '0);
      count_new     = n_new;

      wsum = SW'(h) + SW'(n);
      woff = (wsum >= SW'(QUEUE_DEPTH)) ? wsum - SW'(QUEUE_DEPTH) : wsum;
      tsum = SW'(h_new) + SW'(n_new) - SW'(1);
      toff = (tsum >= SW'(QUEUE_DEPTH)) ? tsum - SW'(QUEUE_DEPTH) : tsum;

      base      = AW'(queue_select) * AW'(QUEUE_DEPTH);
      wr_addr   = base + AW'(woff[HW-1:0]);
      head_addr = base + AW'(h_new);
      tail_addr = base + AW'(toff[HW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (take) begin
         head_ff[queue_select]  <= h_new;
         count_ff[queue_select] <= n_new;
      end
   end

endmodule

// ===== rtl/core/multi_class_fifo_with_plate_check.sv =====
// the plate store read is issued at the accepting edge and the response register loads
// in the S_DONE state once the response register is empty or being taken
// one word at a time: a new request is taken only after the last response is loaded;
// a stalled response holds off the next word
// reset clears head and count of all four queues and the power bounds to 1 and 1000;
// the plate store is not cleared
module multi_class_fifo_with_plate_check #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mcfq_pkg::MODE_W-1:0]    req_mode,
   input  logic [mcfq_pkg::QSEL_W-1:0]    req_queue_select,
   input  logic [mcfq_pkg::PLATE_W-1:0]   req_plate,
   input  logic [mcfq_pkg::POWER_W-1:0]   req_power,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mcfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mcfq_pkg::PLATE_W-1:0]   rsp_head_plate,
   output logic [mcfq_pkg::PLATE_W-1:0]   rsp_tail_plate,
   output logic [mcfq_pkg::OCC_W-1:0]     rsp_occupancy,
   input  logic                           csr_we,
   input  logic [mcfq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mcfq_pkg::POWER_W-1:0]   csr_wdata
);
   import mcfq_pkg::*;

   localparam int AW = $clog2(4 * QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   op_info_type        info, info_ff;
   logic [CW-1:0]      count_new, occ_ff;
   logic [PLATE_W-1:0] plate_ff;
   logic [POWER_W-1:0] floor_ff, ceiling_ff;
   logic [AW-1:0]      wr_addr, head_addr, tail_addr;
   logic [PLATE_W-1:0] rd_head, rd_tail;
   logic               accept, load_rsp;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PLATE_W-1:0]  rsp_head_ff, rsp_head_in;
   logic [PLATE_W-1:0]  rsp_tail_ff, rsp_tail_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   mcfq_qstate #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_qstate (
      .clock         (clock),
      .reset         (reset),
      .take          (accept),
      .mode          (req_mode),
      .queue_select  (req_queue_select),
      .plate         (req_plate),
      .power         (req_power),
      .power_floor   (floor_ff),
      .power_ceiling (ceiling_ff),
      .info          (info),
      .count_new     (count_new),
      .wr_addr       (wr_addr),
      .head_addr     (head_addr),
      .tail_addr     (tail_addr)
   );

   mcfq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
      .clock     (clock),
      .wr_en     (accept && info.wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_plate),
      .rd_en     (accept),
      .rd_addr_a (head_addr),
      .rd_addr_b (tail_addr),
      .rd_data_a (rd_head),
      .rd_data_b (rd_tail)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= POWER_FLOOR_RESET;
         ceiling_ff <= POWER_CEILING_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POWER_FLOOR:   floor_ff   <= csr_wdata;
            CSR_POWER_CEILING: ceiling_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      load_rsp      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_tail_in   = rsp_tail_ff;
      rsp_occ_in    = rsp_occ_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = info_ff.status;
               rsp_occ_in    = OCC_W'(occ_ff);
               if (info_ff.empty) begin
                  rsp_head_in = '0;
                  rsp_tail_in = '0;
               end else begin
                  rsp_head_in = info_ff.fwd_head ? plate_ff : rd_head;
                  rsp_tail_in = info_ff.wr_en ? plate_ff : rd_tail;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
      rsp_occ_ff    <= rsp_occ_in;
      if (accept) begin
         info_ff  <= info;
         occ_ff   <= count_new;
         plate_ff <= req_plate;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_plate = rsp_head_ff;
   assign rsp_tail_plate = rsp_tail_ff;
   assign rsp_occupancy  = rsp_occ_ff;

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while previous word still in flight");

   a_write_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && info_ff.wr_en |-> !info_ff.empty && info_ff.status == STATUS_OK)
      else $error("enqueue left queue empty or with error status");

   a_empty_zero_plates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_head_plate == '0 && rsp_tail_plate == '0)
      else $error("empty status with nonzero plates");

endmodule

// ===== tb/sv/multi_class_fifo_with_plate_check_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the four-class plate fifo: random and directed words,
// in-bench queue model, random stalls on both channels; depends on mcfq_pkg and the rtl
module multi_class_fifo_with_plate_check_tb;
   import mcfq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [QSEL_W-1:0]  queue_select;
      logic [PLATE_W-1:0] plate;
      logic [POWER_W-1:0] power;
   } queue_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PLATE_W-1:0]  head_plate;
      logic [PLATE_W-1:0]  tail_plate;
      logic [OCC_W-1:0]    occupancy;
   } queue_report_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode = MODE_ENQ;
   logic [QSEL_W-1:0]    req_queue_select = '0;
   logic [PLATE_W-1:0]   req_plate = '0;
   logic [POWER_W-1:0]   req_power = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PLATE_W-1:0]   rsp_head_plate;
   logic [PLATE_W-1:0]   rsp_tail_plate;
   logic [OCC_W-1:0]     rsp_occupancy;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POWER_FLOOR;
   logic [POWER_W-1:0]   csr_wdata = '0;

   queue_cmd_type    pending_cmds[$];
   queue_report_type reports_due[$];
   queue_cmd_type    cmd_on_bus;
   queue_report_type oldest_due;
   int               cmds_queued = 0;
   int               reports_seen = 0;
   int               mismatches = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   // queue model
   logic [PLATE_W-1:0] stored_plates[NUM_QUEUES][QUEUE_DEPTH];
   int                 head_slot[NUM_QUEUES] = '{default: 0};
   int                 entries[NUM_QUEUES] = '{default: 0};
   logic [POWER_W-1:0] floor_bound = POWER_FLOOR_RESET;
   logic [POWER_W-1:0] ceiling_bound = POWER_CEILING_RESET;

   multi_class_fifo_with_plate_check #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_queue_select(req_queue_select),
      .req_plate(req_plate),
      .req_power(req_power),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_head_plate(rsp_head_plate),
      .rsp_tail_plate(rsp_tail_plate),
      .rsp_occupancy(rsp_occupancy),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("multi_class_fifo_with_plate_check regression: fail");
      $finish;
   end

   function automatic bit byte_fits(input logic [7:0] c, input bit digit_pos);
      if (digit_pos) begin
         return c >= 8'h30 && c <= 8'h39;
      end
      return c >= 8'h41 && c <= 8'h5A;
   endfunction

   function automatic bit plate_format_ok(input logic [PLATE_W-1:0] plate);
      for (int k = 0; k < PLATE_BYTES; k++) begin
         if (!byte_fits(plate[PLATE_W-1-8*k -: 8], k >= 2 && k <= 5)) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic queue_report_type predict_queue_op(input queue_cmd_type cmd);
      queue_report_type rep;
      int q;
      int n;
      int h;
      q = int'(cmd.queue_select);
      n = entries[q];
      h = head_slot[q];
      rep.status = STATUS_OK;
      case (cmd.mode)
         MODE_ENQ: begin
            if (!plate_format_ok(cmd.plate)) begin
               rep.status = STATUS_BAD_PLATE;
            end else if (!(cmd.power > floor_bound && cmd.power < ceiling_bound)) begin
               rep.status = STATUS_BAD_POWER;
            end else if (n >= QUEUE_DEPTH) begin
               rep.status = STATUS_FULL;
            end else begin
               stored_plates[q][(h + n) % QUEUE_DEPTH] = cmd.plate;
               entries[q] = n + 1;
            end
         end
         MODE_DEQ: begin
            if (n == 0) begin
               rep.status = STATUS_EMPTY;
            end else begin
               head_slot[q] = (h + 1) % QUEUE_DEPTH;
               entries[q] = n - 1;
            end
         end
         MODE_QUERY: begin
            if (n == 0) begin
               rep.status = STATUS_EMPTY;
            end
         end
         default: begin
            rep.status = STATUS_BAD_MODE;
         end
      endcase
      n = entries[q];
      h = head_slot[q];
      if (n == 0) begin
         rep.head_plate = '0;
         rep.tail_plate = '0;
      end else begin
         rep.head_plate = stored_plates[q][h];
         rep.tail_plate = stored_plates[q][(h + n - 1) % QUEUE_DEPTH];
      end
      rep.occupancy = OCC_W'(n);
      return rep;
   endfunction

   function automatic logic [PLATE_W-1:0] valid_plate();
      logic [PLATE_W-1:0] p;
      for (int k = 0; k < PLATE_BYTES; k++) begin
         if (k >= 2 && k <= 5) begin
            p[PLATE_W-1-8*k -: 8] = 8'h30 + 8'($urandom_range(9));
         end else begin
            p[PLATE_W-1-8*k -: 8] = 8'h41 + 8'($urandom_range(25));
         end
      end
      return p;
   endfunction

   function automatic logic [PLATE_W-1:0] break_plate(input logic [PLATE_W-1:0] p);
      int         k;
      bit         digit_pos;
      logic [7:0] c;
      k = $urandom_range(7);
      digit_pos = k >= 2 && k <= 5;
      case ($urandom_range(3))
         0: c = digit_pos ? 8'h2F : 8'h40;
         1: c = digit_pos ? 8'h3A : 8'h5B;
         2: c = digit_pos ? 8'h41 + 8'($urandom_range(25)) : 8'h30 + 8'($urandom_range(9));
         default: begin
            c = 8'($urandom);
            while (byte_fits(c, digit_pos)) begin
               c = 8'($urandom);
            end
         end
      endcase
      p[PLATE_W-1-8*k -: 8] = c;
      return p;
   endfunction

   function automatic logic [POWER_W-1:0] legal_power();
      if (int'(ceiling_bound) > int'(floor_bound) + 1) begin
         return POWER_W'($urandom_range(int'(ceiling_bound) - 1, int'(floor_bound) + 1));
      end
      return POWER_W'($urandom);
   endfunction

   function automatic logic [POWER_W-1:0] illegal_power();
      case ($urandom_range(3))
         0: return floor_bound;
         1: return ceiling_bound;
         2: return POWER_W'($urandom_range(int'(floor_bound), 0));
         default: return POWER_W'($urandom_range(1023, int'(ceiling_bound)));
      endcase
   endfunction

   function automatic void add_cmd(input logic [MODE_W-1:0] mode,
                                   input logic [QSEL_W-1:0] q,
                                   input logic [PLATE_W-1:0] plate,
                                   input logic [POWER_W-1:0] power);
      queue_cmd_type cmd;
      cmd.mode = mode;
      cmd.queue_select = q;
      cmd.plate = plate;
      cmd.power = power;
      pending_cmds.push_back(cmd);
      cmds_queued++;
   endfunction

   // mostly good enqueues to one class, a few rejected ones mixed in
   function automatic void add_enq_burst(input logic [QSEL_W-1:0] q, input int len);
      int pick;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            add_cmd(MODE_ENQ, q, break_plate(valid_plate()), legal_power());
         end else if (pick == 1) begin
            add_cmd(MODE_ENQ, q, valid_plate(), illegal_power());
         end else begin
            add_cmd(MODE_ENQ, q, valid_plate(), legal_power());
         end
      end
   endfunction

   task automatic wait_until_drained();
      while (reports_seen != cmds_queued) begin
         @(posedge clock);
      end
   endtask

   task automatic run_phase(input logic [POWER_W-1:0] lo, input logic [POWER_W-1:0] hi,
                            input int sender_pct, input int receiver_pct, input int n_cmds);
      int goal;
      int pick;
      logic [QSEL_W-1:0] q;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_POWER_FLOOR;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_POWER_CEILING;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we <= 1'b0;
      floor_bound = lo;
      ceiling_bound = hi;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      goal = cmds_queued + n_cmds;
      add_enq_burst(QSEL_W'($urandom_range(3)), $urandom_range(20, 17));
      while (cmds_queued < goal) begin
         pick = $urandom_range(99);
         q = QSEL_W'($urandom_range(3));
         if (pick < 8) begin
            add_enq_burst(q, $urandom_range(18, 4));
         end else if (pick < 14) begin
            repeat ($urandom_range(18, 4)) begin
               add_cmd(MODE_DEQ, q, {$urandom, $urandom}, POWER_W'($urandom));
            end
         end else if (pick < 44) begin
            add_cmd(MODE_ENQ, q, valid_plate(), legal_power());
         end else if (pick < 52) begin
            add_cmd(MODE_ENQ, q, break_plate(valid_plate()), POWER_W'($urandom));
         end else if (pick < 58) begin
            add_cmd(MODE_ENQ, q, valid_plate(), illegal_power());
         end else if (pick < 62) begin
            add_cmd(MODE_ENQ, q, {$urandom, $urandom}, POWER_W'($urandom));
         end else if (pick < 84) begin
            add_cmd(MODE_DEQ, q, {$urandom, $urandom}, POWER_W'($urandom));
         end else if (pick < 94) begin
            add_cmd(MODE_QUERY, q, {$urandom, $urandom}, POWER_W'($urandom));
         end else begin
            add_cmd(MODE_INVALID, q, {$urandom, $urandom}, POWER_W'($urandom));
         end
      end
      wait_until_drained();
   endtask

   task automatic check_field(input string field, input logic [PLATE_W-1:0] expected_v,
                              input logic [PLATE_W-1:0] actual_v);
      if (actual_v !== expected_v) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h",
                  $time, field, expected_v, actual_v);
         mismatches++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reports_due.push_back(predict_queue_op(cmd_on_bus));
         end
         if (!req_valid || req_ready) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_mode <= cmd_on_bus.mode;
               req_queue_select <= cmd_on_bus.queue_select;
               req_plate <= cmd_on_bus.plate;
               req_power <= cmd_on_bus.power;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               $display("%0t ns: response word with nothing expected, status %h",
                        $time, rsp_status);
               mismatches++;
            end else begin
               oldest_due = reports_due.pop_front();
               check_field("status", PLATE_W'(oldest_due.status), PLATE_W'(rsp_status));
               check_field("head_plate", oldest_due.head_plate, rsp_head_plate);
               check_field("tail_plate", oldest_due.tail_plate, rsp_tail_plate);
               check_field("occupancy", PLATE_W'(oldest_due.occupancy),
                           PLATE_W'(rsp_occupancy));
            end
            reports_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed words at reset bounds
      add_cmd(MODE_QUERY, 2'd0, "AA0000AA", 10'd5);
      add_cmd(MODE_DEQ, 2'd1, "AA0000AA", 10'd5);
      add_cmd(MODE_INVALID, 2'd2, "AA0000AA", 10'd5);
      add_cmd(MODE_ENQ, 2'd0, "AA0000AA", 10'd2);
      add_cmd(MODE_ENQ, 2'd0, "ZZ9999ZZ", 10'd999);
      add_cmd(MODE_ENQ, 2'd0, "MN1234PQ", 10'd1);
      add_cmd(MODE_ENQ, 2'd0, "MN1234PQ", 10'd1000);
      add_cmd(MODE_ENQ, 2'd0, "MN1234PQ", 10'd0);
      add_cmd(MODE_ENQ, 2'd0, "MN1234PQ", 10'd1023);
      add_cmd(MODE_ENQ, 2'd1, "@A0000AA", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "A[0000AA", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "AA/000AA", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "AA000:AA", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "AA0000Az", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "AA00005A", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, "AA0B00AA", 10'd500);
      add_cmd(MODE_ENQ, 2'd1, 64'h0, 10'd500);
      add_cmd(MODE_ENQ, 2'd1, {PLATE_W{1'b1}}, 10'd0);
      add_cmd(MODE_ENQ, 2'd1, "DI5551EL", 10'd300);
      add_cmd(MODE_QUERY, 2'd0, 64'h0, 10'd0);
      add_cmd(MODE_INVALID, 2'd1, {PLATE_W{1'b1}}, 10'd1023);
      add_cmd(MODE_DEQ, 2'd0, 64'h0, 10'd0);
      add_cmd(MODE_DEQ, 2'd0, 64'h0, 10'd0);
      add_cmd(MODE_DEQ, 2'd0, 64'h0, 10'd0);
      add_cmd(MODE_QUERY, 2'd1, 64'h0, 10'd0);
      wait_until_drained();

      run_phase(10'd0, 10'd1023, 0, 0, 165);
      run_phase(10'd300, 10'd700, 67, 0, 165);
      run_phase(10'd1023, 10'd0, 0, 67, 165);
      run_phase(10'd1, 10'd1000, 35, 35, 165);
      run_phase(10'd511, 10'd513, 0, 0, 165);
      run_phase(10'd700, 10'd300, 67, 0, 165);
      run_phase(10'd0, 10'd2, 0, 67, 165);
      run_phase(10'd1022, 10'd1023, 35, 35, 165);

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("multi_class_fifo_with_plate_check regression: pass");
      end else begin
         $display("multi_class_fifo_with_plate_check regression: fail");
      end
      $finish;
   end

endmodule
